// ----- rtl/cbt_pkg.sv -----
// Shared constants and controller/datapath interface types for the B-spline tessellator.
package cbt_pkg;

  // Coordinate width (Q16.8) and segment count width.
  localparam int CW = 24;
  localparam int NW = 6;
  localparam int MAX_SEGMENTS = 63;

  // Divider widths: dividend/quotient and divisor/remainder (6 * n^3 < 2^21).
  localparam int DVW = 48;
  localparam int RW = 3 * NW + 3;

  // Forward-difference slots: curve value and first to third differences.
  localparam logic [1:0] SLOT_S  = 2'd0;
  localparam logic [1:0] SLOT_D1 = 2'd1;
  localparam logic [1:0] SLOT_D2 = 2'd2;
  localparam logic [1:0] SLOT_D3 = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_SEGMENTS = 3'd0;
  localparam logic [2:0] REG_CENTER_X = 3'd1;
  localparam logic [2:0] REG_CENTER_Y = 3'd2;
  localparam logic [2:0] REG_ZOOM     = 3'd3;
  localparam logic [2:0] REG_SCREEN_W = 3'd4;
  localparam logic [2:0] REG_SCREEN_H = 3'd5;

  typedef struct packed {
    logic       accept;
    logic       coef;
    logic       m1;
    logic       m2;
    logic       m3;
    logic       div_start;
    logic [1:0] div_sel;
    logic       vcalc;
    logic       vmul;
    logic       emit;
    logic       first;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic          div_done;
    logic          out_free;
    logic [NW-1:0] n;
  } sts_t;

endpackage

// ----- rtl/cbt_div.sv -----
// Sequential restoring divider giving floor quotient and non-negative remainder.
module cbt_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [cbt_pkg::DVW-1:0]  dividend_i,
  input  logic        [cbt_pkg::RW-1:0]   divisor_i,
  output logic                            done_o,
  output logic signed [cbt_pkg::DVW-1:0]  quot_o,
  output logic        [cbt_pkg::RW-1:0]   rem_o
);

  localparam int DVW = cbt_pkg::DVW;
  localparam int RW  = cbt_pkg::RW;
  localparam int CNW = $clog2(DVW + 1);

  logic [DVW-1:0] mag_q;
  logic [RW-1:0]  rem_q;
  logic [RW-1:0]  den_q;
  logic           neg_q;
  logic [CNW-1:0] cnt_q;
  logic           done_q;

  logic [RW:0]    trial;
  logic           ge;
  logic [RW-1:0]  rem_d;
  logic           rnz;

  always_comb begin
    trial = {rem_q, mag_q[DVW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? RW'(trial - {1'b0, den_q}) : trial[RW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNW'(DVW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNW'(1);
        if (cnt_q == CNW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= dividend_i[DVW-1] ? $unsigned(-dividend_i) : $unsigned(dividend_i);
      neg_q <= dividend_i[DVW-1];
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (cnt_q != '0) begin
      mag_q <= {mag_q[DVW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  // A negative dividend with a nonzero remainder rounds one further down.
  always_comb begin
    rnz = rem_q != '0;
    if (neg_q) begin
      quot_o = rnz ? ~$signed(mag_q) : -$signed(mag_q);
      rem_o  = rnz ? den_q - rem_q : rem_q;
    end else begin
      quot_o = $signed(mag_q);
      rem_o  = rem_q;
    end
  end

  assign done_o = done_q;

endmodule

// ----- rtl/cbt_datapath.sv -----
// Datapath: point history, span coefficients, dividers, forward differencing and view mapping.
module cbt_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cbt_pkg::cmd_t                  cmd_i,
  output cbt_pkg::sts_t                  sts_o,
  input  logic [2*cbt_pkg::CW-1:0]       in_data_i,
  input  logic [cbt_pkg::NW-1:0]         segments_i,
  input  logic signed [cbt_pkg::CW-1:0]  center_x_i,
  input  logic signed [cbt_pkg::CW-1:0]  center_y_i,
  input  logic [15:0]                    zoom_i,
  input  logic [12:0]                    screen_width_i,
  input  logic [12:0]                    screen_height_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [31:0]                    out_data_o,
  output logic                           out_start_o,
  output logic                           out_last_o
);

  localparam int CW  = cbt_pkg::CW;
  localparam int NW  = cbt_pkg::NW;
  localparam int RW  = cbt_pkg::RW;
  localparam int DVW = cbt_pkg::DVW;
  localparam int AW  = CW + 4;
  localparam int LW  = AW + NW + 1;
  localparam int TW  = LW + NW + 2;
  localparam int D1W = TW + 1;
  localparam int A6W = AW + 3;
  localparam int D2W = LW + 2;
  localparam int S0W = AW + 3 * NW + 1;
  localparam int PW  = CW + 19;
  localparam int VW  = PW + 1;

  typedef struct packed {
    logic signed [DVW-1:0] q;
    logic        [RW-1:0]  r;
  } qr_t;

  function automatic qr_t qr_add(qr_t a, qr_t b, logic [RW-1:0] den);
    logic [RW:0] s;
    qr_t         res;
    s = {1'b0, a.r} + {1'b0, b.r};
    if (s >= {1'b0, den}) begin
      res.r = RW'(s - {1'b0, den});
      res.q = a.q + b.q + $signed(DVW'(1));
    end else begin
      res.r = s[RW-1:0];
      res.q = a.q + b.q;
    end
    return res;
  endfunction

  logic [NW-1:0]     n_q;
  logic [2*NW-1:0]   n2_q;
  logic [3*NW-1:0]   n3_q;
  logic [RW-1:0]     den_q;
  logic              out_valid_q;
  logic              start_q;
  logic              last_q;
  logic [1:0]        done_ax;
  logic [15:0]       pix [2];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (segments_i == '0) begin
        n_q <= NW'(1);
      end else if (segments_i > NW'(cbt_pkg::MAX_SEGMENTS)) begin
        n_q <= NW'(cbt_pkg::MAX_SEGMENTS);
      end else begin
        n_q <= segments_i;
      end
    end
    if (cmd_i.coef) begin
      n2_q <= n_q * n_q;
    end
    if (cmd_i.m1) begin
      n3_q <= n2_q * n_q;
    end
    if (cmd_i.m2) begin
      den_q <= RW'({n3_q, 2'b00}) + RW'({n3_q, 1'b0});
    end
    if (cmd_i.emit) begin
      start_q <= cmd_i.first;
      last_q  <= cmd_i.last;
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_axis
    logic signed [CW-1:0]  new_pt;
    logic signed [CW-1:0]  ctr;
    logic [12:0]           size;
    logic signed [CW-1:0]  hist_q [3];
    logic signed [CW-1:0]  span_q [4];
    logic signed [AW-1:0]  e0, e1, e2, e3, a_c, b_c, c_c, d_c, b1;
    logic signed [AW-1:0]  a_q, b_q, c_q, d_q;
    logic signed [LW-1:0]  cn_q, bn_q;
    logic signed [A6W-1:0] a6_q;
    logic signed [LW:0]    bc;
    logic signed [TW-1:0]  t1_q;
    logic signed [S0W-1:0] s0_q;
    logic signed [D2W-1:0] d2_q;
    logic signed [D1W-1:0] d1_q;
    logic signed [DVW-1:0] dvd;
    logic signed [DVW-1:0] quot;
    logic [RW-1:0]         rem;
    qr_t                   qr_q [4];
    logic                  rnd;
    logic signed [CW:0]    cval;
    logic signed [CW+1:0]  diff_q;
    logic signed [PW-1:0]  prod_q;
    logic signed [VW-1:0]  halfv, prodv, v, rsum;
    logic signed [VW-17:0] sh;
    logic [15:0]           pix_q;

    assign new_pt = $signed(in_data_i[g*CW +: CW]);
    assign ctr    = (g == 0) ? center_x_i : center_y_i;
    assign size   = (g == 0) ? screen_width_i : screen_height_i;

    // Power-basis coefficients of the span in t^3, t^2, t and constant order.
    always_comb begin
      e0  = AW'(span_q[0]);
      e1  = AW'(span_q[1]);
      e2  = AW'(span_q[2]);
      e3  = AW'(span_q[3]);
      a_c = (e3 - e0) + (e1 - e2) + ((e1 - e2) <<< 1);
      b1  = e0 + e2 - (e1 <<< 1);
      b_c = b1 + (b1 <<< 1);
      c_c = (e2 - e0) + ((e2 - e0) <<< 1);
      d_c = e0 + e2 + (e1 <<< 2);
      bc  = (LW+1)'(b_q) + (LW+1)'(cn_q);
    end

    always_comb begin
      case (cmd_i.div_sel)
        cbt_pkg::SLOT_S:  dvd = DVW'(s0_q);
        cbt_pkg::SLOT_D1: dvd = DVW'(d1_q);
        cbt_pkg::SLOT_D2: dvd = DVW'(d2_q);
        default:          dvd = DVW'(a6_q);
      endcase
    end

    cbt_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (cmd_i.div_start),
      .dividend_i (dvd),
      .divisor_i  (den_q),
      .done_o     (done_ax[g]),
      .quot_o     (quot),
      .rem_o      (rem)
    );

    // Rounded curve value and its screen mapping.
    always_comb begin
      rnd   = {qr_q[0].r, 1'b0} >= {1'b0, den_q};
      cval  = $signed(qr_q[0].q[CW:0]) + $signed({{CW{1'b0}}, rnd});
      halfv = $signed(VW'({size, 15'd0}));
      prodv = VW'(prod_q);
      v     = (g == 0) ? halfv + prodv : halfv - prodv;
      rsum  = v + $signed(VW'(32768));
      sh    = rsum[VW-1:16];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.accept) begin
        hist_q[0] <= hist_q[1];
        hist_q[1] <= hist_q[2];
        hist_q[2] <= new_pt;
        span_q[0] <= hist_q[0];
        span_q[1] <= hist_q[1];
        span_q[2] <= hist_q[2];
        span_q[3] <= new_pt;
      end
      if (cmd_i.coef) begin
        a_q <= a_c;
        b_q <= b_c;
        c_q <= c_c;
        d_q <= d_c;
      end
      if (cmd_i.m1) begin
        cn_q <= c_q * $signed({1'b0, n_q});
        bn_q <= b_q * $signed({1'b0, n_q});
        a6_q <= (A6W'(a_q) <<< 2) + (A6W'(a_q) <<< 1);
      end
      if (cmd_i.m2) begin
        t1_q <= bc * $signed({1'b0, n_q});
        s0_q <= d_q * $signed({1'b0, n3_q});
        d2_q <= D2W'(a6_q) + (D2W'(bn_q) <<< 1);
      end
      if (cmd_i.m3) begin
        d1_q <= D1W'(a_q) + D1W'(t1_q);
      end
      if (done_ax[g]) begin
        qr_q[cmd_i.div_sel].q <= quot;
        qr_q[cmd_i.div_sel].r <= rem;
      end
      if (cmd_i.vcalc) begin
        diff_q <= (CW+2)'(cval) - (CW+2)'(ctr);
      end
      if (cmd_i.vmul) begin
        prod_q <= diff_q * $signed({1'b0, zoom_i});
      end
      if (cmd_i.emit) begin
        if (sh > $signed((VW-16)'(32767))) begin
          pix_q <= 16'h7fff;
        end else if (sh < -$signed((VW-16)'(32768))) begin
          pix_q <= 16'h8000;
        end else begin
          pix_q <= sh[15:0];
        end
        // Step the cubic one sample ahead.
        qr_q[0] <= qr_add(qr_q[0], qr_q[1], den_q);
        qr_q[1] <= qr_add(qr_q[1], qr_q[2], den_q);
        qr_q[2] <= qr_add(qr_q[2], qr_q[3], den_q);
      end
    end

    assign pix[g] = pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.div_done = done_ax[0];
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.n        = n_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {pix[1], pix[0]};
  assign out_start_o = start_q;
  assign out_last_o  = last_q;

endmodule

// ----- rtl/cbt_ctrl.sv -----
// Controller: sequences point intake, span setup, divisions and the vertex loop.
module cbt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_restart_i,
  output logic          in_ready_o,
  output cbt_pkg::cmd_t cmd_o,
  input  cbt_pkg::sts_t sts_i
);

  localparam int NW = cbt_pkg::NW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COEF, ST_M1, ST_M2, ST_M3, ST_DGO, ST_DWAIT, ST_VCALC, ST_VMUL, ST_VEMIT
  } state_e;

  state_e        state_q;
  logic [1:0]    seen_q;
  logic [1:0]    k_q;
  logic [NW-1:0] i_q;
  logic [1:0]    eff_seen;

  assign eff_seen = in_restart_i ? 2'd0 : seen_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = k_q;
    cmd_o.first   = i_q == '0;
    cmd_o.last    = i_q == sts_i.n;
    case (state_q)
      ST_IDLE:  cmd_o.accept    = in_valid_i;
      ST_COEF:  cmd_o.coef      = 1'b1;
      ST_M1:    cmd_o.m1        = 1'b1;
      ST_M2:    cmd_o.m2        = 1'b1;
      ST_M3:    cmd_o.m3        = 1'b1;
      ST_DGO:   cmd_o.div_start = 1'b1;
      ST_VCALC: cmd_o.vcalc     = 1'b1;
      ST_VMUL:  cmd_o.vmul      = 1'b1;
      ST_VEMIT: cmd_o.emit      = sts_i.out_free;
      default:  cmd_o.accept    = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q  <= 2'd0;
      k_q     <= 2'd0;
      i_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (eff_seen == 2'd3) begin
              seen_q  <= 2'd3;
              state_q <= ST_COEF;
            end else begin
              seen_q <= eff_seen + 2'd1;
            end
          end
        end
        ST_COEF: begin
          k_q     <= cbt_pkg::SLOT_S;
          state_q <= ST_M1;
        end
        ST_M1:  state_q <= ST_M2;
        ST_M2:  state_q <= ST_M3;
        ST_M3:  state_q <= ST_DGO;
        ST_DGO: state_q <= ST_DWAIT;
        ST_DWAIT: begin
          if (sts_i.div_done) begin
            if (k_q == cbt_pkg::SLOT_D3) begin
              i_q     <= '0;
              state_q <= ST_VCALC;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= ST_DGO;
            end
          end
        end
        ST_VCALC: state_q <= ST_VMUL;
        ST_VMUL:  state_q <= ST_VEMIT;
        ST_VEMIT: begin
          if (sts_i.out_free) begin
            if (i_q == sts_i.n) begin
              state_q <= ST_IDLE;
            end else begin
              i_q     <= i_q + NW'(1);
              state_q <= ST_VCALC;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = state_q == ST_IDLE;

endmodule

// ----- rtl/cubic_bspline_tessellator_top.sv -----
// Top level of the uniform cubic B-spline tessellator with configuration registers.
// The block takes control points one per transfer and keeps the last three. Once three
// earlier points are held (since reset or since the last point with restart set), each new
// point closes a span of four, and the block emits N+1 screen vertices for it, N being the
// segments register (zero counts as one). Vertex i is the curve at t = i/N, rounded half up
// to Q16.8, then mapped as (x - center_x) * zoom + screen_width/2 and
// -(y - center_y) * zoom + screen_height/2, rounded half up to whole pixels and saturated to
// 16 bits. tuser on the output marks the t = 0 vertex and tlast the t = 1 vertex. A point
// that does not close a span is taken in the idle state and leaves the block idle. A point
// that closes a span passes through the accepting step, coefficient setup in the COEF, M1,
// M2 and M3 states, then four exact divisions per axis by 6 * N^3 on a one-bit-per-cycle
// divider (the two axes in parallel), then per vertex the VCALC, VMUL and VEMIT states
// (center offset, zoom multiply, then rounding with the forward-difference advance) through
// a single output register, VEMIT waiting while that register is full. The output register
// lets the final vertex wait while the next point is taken. Configuration writes are always
// ready and must only be issued while the block is idle.
module cubic_bspline_tessellator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // ctrl_x [23:0], ctrl_y [47:24]
  input  logic        s_axis_tuser,   // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // screen_x [15:0], screen_y [31:16]
  output logic        m_axis_tuser,   // span_start
  output logic        m_axis_tlast,   // last vertex of the span
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  logic [5:0]         segments_q;
  logic signed [23:0] center_x_q;
  logic signed [23:0] center_y_q;
  logic [15:0]        zoom_q;
  logic [12:0]        screen_w_q;
  logic [12:0]        screen_h_q;

  cbt_pkg::cmd_t cmd;
  cbt_pkg::sts_t sts;

  // Register file; writes to an index beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      segments_q <= 6'd1;
      center_x_q <= '0;
      center_y_q <= '0;
      zoom_q     <= 16'd256;
      screen_w_q <= 13'd640;
      screen_h_q <= 13'd480;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cbt_pkg::REG_SEGMENTS: segments_q <= cfg_data_i[5:0];
        cbt_pkg::REG_CENTER_X: center_x_q <= $signed(cfg_data_i);
        cbt_pkg::REG_CENTER_Y: center_y_q <= $signed(cfg_data_i);
        cbt_pkg::REG_ZOOM:     zoom_q     <= cfg_data_i[15:0];
        cbt_pkg::REG_SCREEN_W: screen_w_q <= cfg_data_i[12:0];
        cbt_pkg::REG_SCREEN_H: screen_h_q <= cfg_data_i[12:0];
        default:               segments_q <= segments_q;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  cbt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_restart_i (s_axis_tuser),
    .in_ready_o   (s_axis_tready),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  cbt_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_data_i       (s_axis_tdata),
    .segments_i      (segments_q),
    .center_x_i      (center_x_q),
    .center_y_i      (center_y_q),
    .zoom_i          (zoom_q),
    .screen_width_i  (screen_w_q),
    .screen_height_i (screen_h_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_o      (m_axis_tdata),
    .out_start_o     (m_axis_tuser),
    .out_last_o      (m_axis_tlast)
  );

endmodule

// ----- rtl/cbt_checker.sv -----
// Port-level checker for the tessellator, bound to the top level.
module cbt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled vertex keeps its valid and contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output vertex changed");

  // A span has at least two vertices, so no vertex both starts and ends it.
  a_start_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser && m_axis_tlast))
    else $error("vertex marked both first and last");

  // While a span is still being emitted no new point is taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready in the middle of a span");

  // Reset leaves no vertex pending.
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind cubic_bspline_tessellator_top cbt_checker u_cbt_checker (.*);

// ----- tb/sv/cbt_checker.sv -----
// Checker that predicts and compares the tessellator's vertex stream.
module cbt_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [47:0] s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic        m_tuser_i,
  input  logic        m_tlast_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          vertices_o,
  output int          spans_o
);

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic        first;
    logic        last;
  } vertex_t;

  vertex_t vertex_q[$];

  logic [5:0]          seg_r;
  logic signed [23:0]  ctr_x_r, ctr_y_r;
  logic [15:0]         zoom_r;
  logic [12:0]         scr_w_r, scr_h_r;
  logic signed [23:0]  hist_x[3], hist_y[3];
  int                  seen;

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint blend(longint p0, longint p1, longint p2, longint p3,
                                   longint w0, longint w1, longint w2, longint w3,
                                   longint den);
    longint s;
    s = w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3;
    return fdiv(2 * s + den, 2 * den);
  endfunction

  task automatic tessellate(logic signed [23:0] nx, logic signed [23:0] ny);
    longint n, n3, den, u, i2, i3, w0, w1, w2, w3, cx, cy, vx, vy;
    vertex_t v;
    n = (seg_r == 0) ? 1 : seg_r;
    if (n > cbt_pkg::MAX_SEGMENTS) n = cbt_pkg::MAX_SEGMENTS;
    n3 = n * n * n;
    den = 6 * n3;
    for (longint i = 0; i <= n; i++) begin
      u = n - i;
      i2 = i * i;
      i3 = i2 * i;
      w0 = u * u * u;
      w1 = 3 * i3 - 6 * i2 * n + 4 * n3;
      w2 = -3 * i3 + 3 * i2 * n + 3 * i * n * n + n3;
      w3 = i3;
      cx = blend(hist_x[0], hist_x[1], hist_x[2], nx, w0, w1, w2, w3, den);
      cy = blend(hist_y[0], hist_y[1], hist_y[2], ny, w0, w1, w2, w3, den);
      vx = (cx - longint'(ctr_x_r)) * longint'(zoom_r) + (longint'(scr_w_r) <<< 15);
      vy = -((cy - longint'(ctr_y_r)) * longint'(zoom_r)) + (longint'(scr_h_r) <<< 15);
      v.sx = clamp16(fdiv(vx + 32768, 65536));
      v.sy = clamp16(fdiv(vy + 32768, 65536));
      v.first = (i == 0);
      v.last = (i == n);
      vertex_q.push_back(v);
    end
  endtask

  task automatic report(string what, longint want, longint got);
    $display("mismatch on vertex %0d: %s expected %0d got %0d", vertices_o, what, want, got);
    errors_o++;
  endtask

  // Signals are driven at the rising edge, so sampling at the falling edge sees
  // exactly what the next rising edge will transfer.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_r <= 6'd1; ctr_x_r <= '0; ctr_y_r <= '0; zoom_r <= 16'd256;
      scr_w_r <= 13'd640; scr_h_r <= 13'd480;
      for (int k = 0; k < 3; k++) begin
        hist_x[k] = '0; hist_y[k] = '0;
      end
      seen = 0;
      vertex_q.delete();
      errors_o = 0; pending_o = 0; vertices_o = 0; spans_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          cbt_pkg::REG_SEGMENTS: seg_r <= cfg_data_i[5:0];
          cbt_pkg::REG_CENTER_X: ctr_x_r <= cfg_data_i;
          cbt_pkg::REG_CENTER_Y: ctr_y_r <= cfg_data_i;
          cbt_pkg::REG_ZOOM:     zoom_r <= cfg_data_i[15:0];
          cbt_pkg::REG_SCREEN_W: scr_w_r <= cfg_data_i[12:0];
          cbt_pkg::REG_SCREEN_H: scr_h_r <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i) begin
          for (int k = 0; k < 3; k++) begin
            hist_x[k] = '0; hist_y[k] = '0;
          end
          seen = 0;
        end
        if (seen >= 3) begin
          tessellate(s_tdata_i[23:0], s_tdata_i[47:24]);
          spans_o++;
        end
        hist_x[0] = hist_x[1]; hist_x[1] = hist_x[2]; hist_x[2] = s_tdata_i[23:0];
        hist_y[0] = hist_y[1]; hist_y[1] = hist_y[2]; hist_y[2] = s_tdata_i[47:24];
        if (seen < 3) seen++;
      end
      if (m_tvalid_i && m_tready_i) begin
        if (vertex_q.size() == 0) begin
          report("outstanding vertices", 0, 1);
        end else begin
          vertex_t want;
          want = vertex_q.pop_front();
          if (m_tdata_i[15:0] !== want.sx)
            report("screen_x", $signed(want.sx), $signed(m_tdata_i[15:0]));
          if (m_tdata_i[31:16] !== want.sy)
            report("screen_y", $signed(want.sy), $signed(m_tdata_i[31:16]));
          if (m_tuser_i !== want.first) report("span_start", want.first, m_tuser_i);
          if (m_tlast_i !== want.last) report("last", want.last, m_tlast_i);
        end
        vertices_o++;
      end
      pending_o = vertex_q.size();
    end
  end

endmodule

// ----- tb/sv/cubic_bspline_tessellator_top_tb.sv -----
// Testbench top: clock, reset, stimulus and verdict for the B-spline tessellator.
module cubic_bspline_tessellator_top_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // ctrl_x [23:0], ctrl_y [47:24]
  logic        s_axis_tuser = 1'b0; // restart
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // screen_x [15:0], screen_y [31:16]
  logic        m_axis_tuser;        // span_start
  logic        m_axis_tlast;        // last vertex of the span
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  int errors, pending, vertices, spans;
  int points_sent = 0;
  int cfg_writes = 0;
  int burst_left = 0;
  int cycles = 0;
  bit hold_request = 0;

  // Generous bound on the whole run, even with a busy receiver.
  localparam int CYCLE_LIMIT = 3000000;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cubic_bspline_tessellator_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  cbt_scoreboard checker_i (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser), .m_tlast_i(m_axis_tlast),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .vertices_o(vertices), .spans_o(spans)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d vertices still outstanding", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver switches at random between stall patterns: always ready, coin
  // flip, or mostly stalled. Once, on request, it holds off for a long stretch
  // so the block fills up and has to stop taking control points.
  initial begin
    int hold_left;
    int mode;
    bit hold_done;
    hold_left = 0;
    mode = 0;
    hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_request && !hold_done) begin
        hold_done = 1;
        hold_left = 2000;
        m_axis_tready <= 1'b0;
      end else begin
        if (cycles % 64 == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // One control point transfer. The sender works in bursts; between bursts
  // tvalid usually drops for a random gap.
  task automatic send_point(logic [23:0] x, logic [23:0] y, logic restart);
    bit rdy;
    if (burst_left == 0) begin
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    s_axis_tuser <= restart;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    burst_left--;
    points_sent++;
  endtask

  // Stop offering points and wait until every predicted vertex has arrived,
  // plus a short tail for a point that closes no span.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  // Each write ends with the configuration channel idle.
  task automatic write_reg(logic [2:0] idx, logic [23:0] value);
    bit rdy;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    cfg_writes++;
  endtask

  task automatic set_view(logic [5:0] seg, logic [23:0] cx, logic [23:0] cy,
                          logic [15:0] zm, logic [12:0] sw, logic [12:0] sh);
    drain();
    write_reg(cbt_pkg::REG_SEGMENTS, 24'(seg));
    write_reg(cbt_pkg::REG_CENTER_X, cx);
    write_reg(cbt_pkg::REG_CENTER_Y, cy);
    write_reg(cbt_pkg::REG_ZOOM, 24'(zm));
    write_reg(cbt_pkg::REG_SCREEN_W, 24'(sw));
    write_reg(cbt_pkg::REG_SCREEN_H, 24'(sh));
  endtask

  // Half of the coordinates near the origin so that vertices land on screen, the
  // rest full-range values and the two extremes.
  function automatic logic [23:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return 24'($urandom());
      default: return 24'($signed($urandom_range(0, 32767)) - 16384);
    endcase
  endfunction

  // Random traffic: mostly whole point lists opened by a restart, some lists
  // cut short before they close a span, and a little stray restart noise.
  task automatic random_lists(int count);
    int len;
    while (count > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 10);
      for (int k = 0; k < len && count > 0; k++) begin
        send_point(pick_coord(), pick_coord(),
                   k == 0 ? 1'b1 : ($urandom_range(0, 30) == 0));
        count--;
      end
    end
  endtask

  // Random phases take about 25 points each; the last one slightly more.
  function automatic int powersafe(int phase);
    return (phase == 7) ? 34 : 25;
  endfunction

  initial begin
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points under the reset settings: a list that is too short,
    // the coordinate extremes, a restart in the middle of a list and a list
    // that closes several spans in a row.
    send_point(24'h000000, 24'h000000, 1'b1);
    send_point(24'h7FFFFF, 24'h800000, 1'b0);
    send_point(24'h000100, 24'hFFFF00, 1'b1);
    send_point(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_point(24'h800000, 24'h800000, 1'b0);
    send_point(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_point(24'h800000, 24'h800000, 1'b0);
    send_point(24'h001000, 24'h002000, 1'b1);
    send_point(24'hFFF000, 24'h003000, 1'b0);
    send_point(24'h000080, 24'hFFFF80, 1'b0);
    send_point(24'h000040, 24'h000040, 1'b0);
    send_point(24'hFFFFFF, 24'h000001, 1'b0);
    send_point(24'h555555, 24'hAAAAAA, 1'b0);
    send_point(24'hAAAAAA, 24'h555555, 1'b0);
    send_point(24'h000000, 24'h000000, 1'b1);

    // Zero segments count as one; centers and zoom at their extremes.
    set_view(6'd0, 24'h7FFFFF, 24'h800000, 16'hFFFF, 13'd4096, 13'd4096);
    send_point(24'h7FFFFF, 24'h800000, 1'b1);
    send_point(24'h800000, 24'h7FFFFF, 1'b0);
    send_point(24'h7FFFFF, 24'h800000, 1'b0);
    send_point(24'h800000, 24'h7FFFFF, 1'b0);
    random_lists(20);

    // The largest segment count, kept to a few spans since each is long.
    set_view(6'd63, 24'h000000, 24'h000000, 16'd256, 13'd640, 13'd480);
    random_lists(12);

    // Zoom and screen size of zero are used as they are; writes to the unused
    // register indexes must change nothing.
    set_view(6'd4, 24'hFFFF00, 24'h000100, 16'd0, 13'd0, 13'd0);
    write_reg(3'd6, 24'hFFFFFF);
    write_reg(3'd7, 24'h123456);
    random_lists(20);

    set_view(6'd1, 24'h800000, 24'h7FFFFF, 16'd1, 13'd1, 13'd1);
    random_lists(20);

    // Small views with a long receiver hold-off in the middle, then a full
    // stop of the sender until every vertex is back.
    set_view(6'd3, 24'h000000, 24'h000000, 16'd512, 13'd800, 13'd600);
    random_lists(20);
    hold_request = 1;
    random_lists(30);
    drain();
    random_lists(20);

    for (int p = 0; p < 8; p++) begin
      set_view(6'($urandom_range(1, 12)),
               ($urandom_range(0, 1) == 0) ? 24'($urandom()) : 24'h000000,
               ($urandom_range(0, 1) == 0) ? 24'($urandom()) : 24'h000000,
               16'($urandom_range(1, 65535)), 13'($urandom_range(1, 4096)),
               13'($urandom_range(1, 4096)));
      random_lists(powersafe(p));
    end

    drain();
    repeat (300) @(posedge clk_i);
    $display("Sent %0d control points through %0d register writes; %0d spans closed.",
             points_sent, cfg_writes, spans);
    $display("Compared %0d vertices, %0d mismatches.", vertices, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cbt_pkg.sv
rtl/cbt_div.sv
rtl/cbt_datapath.sv
rtl/cbt_ctrl.sv
rtl/cubic_bspline_tessellator_top.sv
rtl/cbt_checker.sv
tb/sv/cbt_checker.sv
tb/sv/cubic_bspline_tessellator_top_tb.sv
